// ----- rtl/fcpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fcpa_pkg
// Shared constants for the fixed chunk pool allocator: field widths, pool
// depth, item kinds, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package fcpa_pkg;

	localparam int MAX_CHUNKS = 1024;
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int SIZE_W     = 16;
	localparam int ADDR_W     = 32;
	localparam int KIND_W     = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = IDX_W + SIZE_W;

	localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(MAX_CHUNKS);

	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NONE_USED = 2'd2;
	localparam logic [STAT_W-1:0] ST_SIZE      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

endpackage

// ----- rtl/fixed_chunk_pool_allocator_core.sv -----
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator_core
// Fixed-size chunk pool with a LIFO free list of chunk indices held in RAM.
// ----------------------------------------------------------------------------
// Operation: one item at a time; in_stall is high until the result is loaded.
//   A granted allocate steps through stack RAM read, index multiply, base add
//   and result load; a pool reset fills the stack RAM one entry per cycle with
//   n entries, n being chunk_count saturated to the pool depth. The result load
//   waits while out_stall holds a result that has not been taken.
// Reset: the pool is empty and the in-use and peak counts zero; stack RAM contents undefined.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [fcpa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fcpa_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [fcpa_pkg::KIND_W-1:0]            kind,
	input  logic [fcpa_pkg::SIZE_W-1:0]            request_size,
	input  logic [fcpa_pkg::IDX_W-1:0]             chunk_index,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [fcpa_pkg::STAT_W-1:0]            status,
	output logic [fcpa_pkg::IDX_W-1:0]             granted_index,
	output logic [fcpa_pkg::ADDR_W-1:0]            granted_address,
	output logic [fcpa_pkg::CNT_W-1:0]             used_chunks,
	output logic [fcpa_pkg::CNT_W-1:0]             peak_chunks
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_FILL = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]                      state_q;
	logic [fcpa_pkg::CNT_W-1:0]      chunk_count_q;
	logic [fcpa_pkg::SIZE_W-1:0]     chunk_size_q;
	logic [fcpa_pkg::ADDR_W-1:0]     base_address_q;
	logic [fcpa_pkg::CNT_W-1:0]      top_q;
	logic [fcpa_pkg::CNT_W-1:0]      used_q;
	logic [fcpa_pkg::CNT_W-1:0]      peak_q;
	logic [fcpa_pkg::IDX_W-1:0]      fill_q;
	logic [fcpa_pkg::STAT_W-1:0]     res_status_q;
	logic [fcpa_pkg::IDX_W-1:0]      res_index_q;
	logic [fcpa_pkg::ADDR_W-1:0]     res_address_q;
	logic [fcpa_pkg::PROD_W-1:0]     prod_s1;
	logic                            out_valid_q;
	logic [fcpa_pkg::STAT_W-1:0]     status_q;
	logic [fcpa_pkg::IDX_W-1:0]      granted_index_q;
	logic [fcpa_pkg::ADDR_W-1:0]     granted_address_q;
	logic [fcpa_pkg::CNT_W-1:0]      used_chunks_q;
	logic [fcpa_pkg::CNT_W-1:0]      peak_chunks_q;

	logic                            accept;
	logic                            out_free;
	logic [fcpa_pkg::CNT_W-1:0]      fill_n;
	logic [fcpa_pkg::CNT_W-1:0]      used_inc;
	logic                            mem_we;
	logic [fcpa_pkg::IDX_W-1:0]      mem_waddr;
	logic [fcpa_pkg::IDX_W-1:0]      mem_wdata;
	logic                            mem_re;
	logic [fcpa_pkg::IDX_W-1:0]      mem_raddr;
	logic [fcpa_pkg::IDX_W-1:0]      mem_rdata;
	logic [fcpa_pkg::CNT_W-1:0]      top_dec;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign fill_n    = (chunk_count_q > fcpa_pkg::POOL_MAX) ? fcpa_pkg::POOL_MAX
	                                                         : chunk_count_q;
	assign used_inc  = used_q + fcpa_pkg::CNT_W'(1);
	assign top_dec   = top_q - fcpa_pkg::CNT_W'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = top_q[fcpa_pkg::IDX_W-1:0];
		mem_wdata = chunk_index;
		if (state_q == S_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = fill_q;
			mem_wdata = fill_q;
		end else if (accept && kind == fcpa_pkg::KIND_FREE && used_q != '0
		             && top_q < fcpa_pkg::POOL_MAX) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re    = accept && kind == fcpa_pkg::KIND_ALLOC;
	assign mem_raddr = top_dec[fcpa_pkg::IDX_W-1:0];

	fcpa_ram #(
		.WIDTH(fcpa_pkg::IDX_W),
		.DEPTH(fcpa_pkg::MAX_CHUNKS)
	) u_stack (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q  <= fcpa_pkg::POOL_MAX;
			chunk_size_q   <= fcpa_pkg::SIZE_W'(16);
			base_address_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fcpa_pkg::REG_CHUNK_COUNT:  chunk_count_q  <= cfg_data[fcpa_pkg::CNT_W-1:0];
				fcpa_pkg::REG_CHUNK_SIZE:   chunk_size_q   <= cfg_data[fcpa_pkg::SIZE_W-1:0];
				fcpa_pkg::REG_BASE_ADDRESS: base_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= '0;
			used_q  <= '0;
			peak_q  <= '0;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind)
							fcpa_pkg::KIND_ALLOC: begin
								if (request_size == chunk_size_q && top_q != '0) begin
									state_q <= S_READ;
									top_q   <= top_dec;
									used_q  <= used_inc;
									if (used_inc > peak_q) begin
										peak_q <= used_inc;
									end
								end else begin
									state_q <= S_DONE;
								end
							end
							fcpa_pkg::KIND_FREE: begin
								state_q <= S_DONE;
								if (used_q != '0) begin
									if (top_q < fcpa_pkg::POOL_MAX) begin
										top_q <= top_q + fcpa_pkg::CNT_W'(1);
									end
									used_q <= used_q - fcpa_pkg::CNT_W'(1);
								end
							end
							fcpa_pkg::KIND_RESET: begin
								top_q  <= fill_n;
								used_q <= '0;
								peak_q <= '0;
								fill_q <= '0;
								if (fill_n != '0) begin
									state_q <= S_FILL;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: state_q <= S_ADD;
				S_ADD:  state_q <= S_DONE;
				S_FILL: begin
					fill_q <= fill_q + fcpa_pkg::IDX_W'(1);
					if ({1'b0, fill_q} == top_dec) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_index_q   <= '0;
			res_address_q <= '0;
			if (kind == fcpa_pkg::KIND_ALLOC && request_size != chunk_size_q) begin
				res_status_q <= fcpa_pkg::ST_SIZE;
			end else if (kind == fcpa_pkg::KIND_ALLOC && top_q == '0) begin
				res_status_q <= fcpa_pkg::ST_EMPTY;
			end else if (kind == fcpa_pkg::KIND_FREE && used_q == '0) begin
				res_status_q <= fcpa_pkg::ST_NONE_USED;
			end else begin
				res_status_q <= fcpa_pkg::ST_OK;
			end
		end
		if (state_q == S_READ) begin
			res_index_q <= mem_rdata;
			prod_s1     <= fcpa_pkg::PROD_W'(mem_rdata) * fcpa_pkg::PROD_W'(chunk_size_q);
		end
		if (state_q == S_ADD) begin
			res_address_q <= base_address_q + fcpa_pkg::ADDR_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q          <= res_status_q;
			granted_index_q   <= res_index_q;
			granted_address_q <= res_address_q;
			used_chunks_q     <= used_q;
			peak_chunks_q     <= peak_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_index   = granted_index_q;
	assign granted_address = granted_address_q;
	assign used_chunks     = used_chunks_q;
	assign peak_chunks     = peak_chunks_q;

	a_peak_covers_used: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= used_q)
		else $error("peak count below in-use count");

	a_read_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> $past(accept) && $past(kind) == fcpa_pkg::KIND_ALLOC)
		else $error("stack read without allocate transaction");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> {1'b0, fill_q} < top_q)
		else $error("fill pointer beyond pool size");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside completion state");

endmodule

// ----- rtl/fcpa_ram.sv -----
// ----------------------------------------------------------------------------
// fcpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fcpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- tb/sv/fixed_chunk_pool_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator_core_tb
// Feeds allocate, free, pool reset and unused-kind transactions into the chunk
// pool core under a series of register settings and changing back-pressure.
// A private copy of the LIFO free list predicts every result, and each result
// is compared field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator_core_tb;

	localparam logic [fcpa_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 8000000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [fcpa_pkg::STAT_W-1:0] status;
		logic [fcpa_pkg::IDX_W-1:0]  index;
		logic [fcpa_pkg::ADDR_W-1:0] address;
		logic [fcpa_pkg::CNT_W-1:0]  used;
		logic [fcpa_pkg::CNT_W-1:0]  peak;
	} pool_reply_t;

	class pool_tracker;
		logic [fcpa_pkg::IDX_W-1:0]  free_list [fcpa_pkg::MAX_CHUNKS];
		logic [fcpa_pkg::CNT_W-1:0]  top;
		logic [fcpa_pkg::CNT_W-1:0]  in_use;
		logic [fcpa_pkg::CNT_W-1:0]  peak;
		logic [fcpa_pkg::CNT_W-1:0]  cfg_count;
		logic [fcpa_pkg::SIZE_W-1:0] cfg_size;
		logic [fcpa_pkg::ADDR_W-1:0] cfg_base;
		logic [fcpa_pkg::IDX_W-1:0]  held [$];
		pool_reply_t                 replies_due [$];
		int                          replies_seen;
		int                          failures;
		int                          mismatches;
		int                          refills;
		int                          status_tally [4];

		function new();
			top          = '0;
			in_use       = '0;
			peak         = '0;
			cfg_count    = fcpa_pkg::POOL_MAX;
			cfg_size     = fcpa_pkg::SIZE_W'(16);
			cfg_base     = '0;
			replies_seen = 0;
			failures     = 0;
			mismatches   = 0;
			refills      = 0;
			foreach (status_tally[i]) status_tally[i] = 0;
		endfunction

		function void write_reg(logic [fcpa_pkg::CFG_IDX_W-1:0] idx,
				logic [fcpa_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				fcpa_pkg::REG_CHUNK_COUNT:  cfg_count = data[fcpa_pkg::CNT_W-1:0];
				fcpa_pkg::REG_CHUNK_SIZE:   cfg_size  = data[fcpa_pkg::SIZE_W-1:0];
				fcpa_pkg::REG_BASE_ADDRESS: cfg_base  = data[fcpa_pkg::ADDR_W-1:0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return replies_due.size();
		endfunction

		function void note_request(logic [fcpa_pkg::KIND_W-1:0] k,
				logic [fcpa_pkg::SIZE_W-1:0] req, logic [fcpa_pkg::IDX_W-1:0] idx);
			pool_reply_t r;
			int fill;
			int j;
			r = '0;
			r.status = fcpa_pkg::ST_OK;
			case (k)
				fcpa_pkg::KIND_ALLOC: begin
					if (req != cfg_size)
						r.status = fcpa_pkg::ST_SIZE;
					else if (top == '0)
						r.status = fcpa_pkg::ST_EMPTY;
					else begin
						top       = top - fcpa_pkg::CNT_W'(1);
						r.index   = free_list[top[fcpa_pkg::IDX_W-1:0]];
						r.address = cfg_base + fcpa_pkg::ADDR_W'(r.index)
							* fcpa_pkg::ADDR_W'(cfg_size);
						in_use    = in_use + fcpa_pkg::CNT_W'(1);
						if (in_use > peak) peak = in_use;
						held.push_back(r.index);
					end
				end
				fcpa_pkg::KIND_FREE: begin
					if (in_use == '0)
						r.status = fcpa_pkg::ST_NONE_USED;
					else begin
						if (top < fcpa_pkg::POOL_MAX) begin
							free_list[top[fcpa_pkg::IDX_W-1:0]] = idx;
							top = top + fcpa_pkg::CNT_W'(1);
						end
						in_use = in_use - fcpa_pkg::CNT_W'(1);
						j = 0;
						while (j < held.size() && held[j] != idx) j++;
						if (j < held.size()) held.delete(j);
					end
				end
				fcpa_pkg::KIND_RESET: begin
					fill = (cfg_count > fcpa_pkg::POOL_MAX) ? fcpa_pkg::MAX_CHUNKS
						: int'(cfg_count);
					for (j = 0; j < fill; j++) free_list[j] = fcpa_pkg::IDX_W'(j);
					top    = fcpa_pkg::CNT_W'(fill);
					in_use = '0;
					peak   = '0;
					held.delete();
					refills++;
				end
				default: ;
			endcase
			r.used = in_use;
			r.peak = peak;
			replies_due.push_back(r);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				failures++;
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result %0d, %s: expected 0x%0h, got 0x%0h",
						replies_seen, field, want, got);
			end
		endfunction

		function void check_reply(pool_reply_t got);
			pool_reply_t want;
			replies_seen++;
			if (replies_due.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result %0d with no transaction pending: status %0d index %0d",
						replies_seen, got.status, got.index);
				return;
			end
			want = replies_due.pop_front();
			status_tally[want.status]++;
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("granted_index", 32'(want.index), 32'(got.index));
			compare_field("granted_address", want.address, got.address);
			compare_field("used_chunks", 32'(want.used), 32'(got.used));
			compare_field("peak_chunks", 32'(want.peak), 32'(got.peak));
		endfunction

		function void flush_leftovers();
			if (replies_due.size() != 0) begin
				failures += replies_due.size();
				$display("%0d results never arrived", replies_due.size());
			end
		endfunction
	endclass

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            cfg_wr_en    = 1'b0;
	logic [fcpa_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [fcpa_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
	logic                            in_valid     = 1'b0;
	logic                            in_stall;
	logic [fcpa_pkg::KIND_W-1:0]     kind         = '0;
	logic [fcpa_pkg::SIZE_W-1:0]     request_size = '0;
	logic [fcpa_pkg::IDX_W-1:0]      chunk_index  = '0;
	logic                            out_valid;
	logic                            out_stall    = 1'b0;
	logic [fcpa_pkg::STAT_W-1:0]     status;
	logic [fcpa_pkg::IDX_W-1:0]      granted_index;
	logic [fcpa_pkg::ADDR_W-1:0]     granted_address;
	logic [fcpa_pkg::CNT_W-1:0]      used_chunks;
	logic [fcpa_pkg::CNT_W-1:0]      peak_chunks;

	pool_tracker tracker = new();
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int cycle_count     = 0;
	int items_sent      = 0;
	int settings_loaded = 0;

	fixed_chunk_pool_allocator_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.request_size    (request_size),
		.chunk_index     (chunk_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.granted_index   (granted_index),
		.granted_address (granted_address),
		.used_chunks     (used_chunks),
		.peak_chunks     (peak_chunks)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_reply({status, granted_index, granted_address,
				used_chunks, peak_chunks});
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic drive_item(logic [fcpa_pkg::KIND_W-1:0] k,
			logic [fcpa_pkg::SIZE_W-1:0] rs, logic [fcpa_pkg::IDX_W-1:0] ci);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		request_size <= rs;
		chunk_index  <= ci;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_request(k, rs, ci);
		items_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every pending result is back and the core is idle
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_reg(logic [fcpa_pkg::CFG_IDX_W-1:0] idx,
			logic [fcpa_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic load_settings(logic [fcpa_pkg::CNT_W-1:0] cnt,
			logic [fcpa_pkg::SIZE_W-1:0] sz, logic [fcpa_pkg::ADDR_W-1:0] base);
		put_reg(fcpa_pkg::REG_CHUNK_COUNT, fcpa_pkg::CFG_DATA_W'(cnt));
		put_reg(fcpa_pkg::REG_CHUNK_SIZE, fcpa_pkg::CFG_DATA_W'(sz));
		put_reg(fcpa_pkg::REG_BASE_ADDRESS, fcpa_pkg::CFG_DATA_W'(base));
		cfg_wr_en <= 1'b0;
		settings_loaded++;
		@(negedge clk);
	endtask

	task automatic run_segment(int n_items);
		logic [fcpa_pkg::CNT_W-1:0]  cnt;
		logic [fcpa_pkg::SIZE_W-1:0] sz;
		logic [fcpa_pkg::ADDR_W-1:0] base;
		logic [fcpa_pkg::SIZE_W-1:0] rs;
		logic [fcpa_pkg::IDX_W-1:0]  ci;
		int alloc_bias;
		int pick;
		int span;
		int i;
		case ($urandom_range(7))
			0: cnt = fcpa_pkg::CNT_W'(1);
			1: cnt = fcpa_pkg::POOL_MAX;
			2: cnt = fcpa_pkg::CNT_W'($urandom_range(2047, fcpa_pkg::MAX_CHUNKS + 1));
			default: cnt = fcpa_pkg::CNT_W'($urandom_range(48, 2));
		endcase
		case ($urandom_range(5))
			0: sz = fcpa_pkg::SIZE_W'(1);
			1: sz = 16'hFFFF;
			default: sz = fcpa_pkg::SIZE_W'($urandom_range(65535, 1));
		endcase
		case ($urandom_range(5))
			0: base = '0;
			1: base = '1;
			default: base = $urandom;
		endcase
		settle();
		load_settings(cnt, sz, base);
		drive_item(fcpa_pkg::KIND_RESET, fcpa_pkg::SIZE_W'($urandom),
			fcpa_pkg::IDX_W'($urandom));
		span = (cnt > fcpa_pkg::POOL_MAX) ? fcpa_pkg::MAX_CHUNKS : int'(cnt);
		alloc_bias = 75;
		for (i = 0; i < n_items; i++) begin
			if (i % 16 == 15) alloc_bias = 100 - alloc_bias;
			rs   = fcpa_pkg::SIZE_W'($urandom);
			ci   = fcpa_pkg::IDX_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 4)
				drive_item(fcpa_pkg::KIND_RESET, rs, ci);
			else if (pick < 7)
				drive_item(KIND_UNUSED, rs, ci);
			else if ($urandom_range(99) < alloc_bias) begin
				if ($urandom_range(99) < 88) rs = tracker.cfg_size;
				drive_item(fcpa_pkg::KIND_ALLOC, rs, ci);
			end else begin
				if (tracker.held.size() != 0 && $urandom_range(99) < 80)
					ci = tracker.held[$urandom_range(tracker.held.size() - 1)];
				else if ($urandom_range(1) == 1)
					ci = fcpa_pkg::IDX_W'($urandom_range(span - 1));
				drive_item(fcpa_pkg::KIND_FREE, rs, ci);
			end
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pool still empty after reset, register defaults in force
		drive_item(fcpa_pkg::KIND_ALLOC, 16, 0);
		drive_item(fcpa_pkg::KIND_FREE, 0, 0);
		drive_item(KIND_UNUSED, 16'hFFFF, 10'h3FF);
		drive_item(fcpa_pkg::KIND_ALLOC, 17, 0);

		// small pool, widest size, addresses wrap past the top
		settle();
		load_settings(4, 16'hFFFF, 32'hFFFF_FFF0);
		drive_item(fcpa_pkg::KIND_RESET, 0, 0);
		repeat (4) drive_item(fcpa_pkg::KIND_ALLOC, 16'hFFFF, 0);
		drive_item(fcpa_pkg::KIND_ALLOC, 16'hFFFF, 0);
		drive_item(fcpa_pkg::KIND_ALLOC, 0, 0);
		drive_item(fcpa_pkg::KIND_FREE, 0, 10'h3FF);
		drive_item(fcpa_pkg::KIND_FREE, 0, 10'h3FF);
		drive_item(fcpa_pkg::KIND_ALLOC, 16'hFFFF, 0);
		drive_item(KIND_UNUSED, 0, 0);

		// count above the pool depth saturates
		settle();
		load_settings(11'h7FF, 1, '0);
		drive_item(fcpa_pkg::KIND_RESET, 0, 0);
		drive_item(fcpa_pkg::KIND_ALLOC, 1, 0);
		drive_item(fcpa_pkg::KIND_FREE, 0, 0);
		drive_item(fcpa_pkg::KIND_ALLOC, 1, 0);

		// zero count leaves the pool empty
		settle();
		load_settings(0, 1, 32'hFFFF_FFFF);
		drive_item(fcpa_pkg::KIND_RESET, 0, 0);
		drive_item(fcpa_pkg::KIND_ALLOC, 1, 0);
		drive_item(fcpa_pkg::KIND_FREE, 0, 5);

		// single chunk pool
		settle();
		load_settings(1, 16'h8000, 32'h8000_0000);
		drive_item(fcpa_pkg::KIND_RESET, 0, 0);
		drive_item(fcpa_pkg::KIND_ALLOC, 16'h8000, 0);
		drive_item(fcpa_pkg::KIND_ALLOC, 16'h8000, 0);

		send_idle_pct = 15;
		recv_idle_pct = 74;
		repeat (4) run_segment(117);
		send_idle_pct = 74;
		recv_idle_pct = 15;
		repeat (4) run_segment(117);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) run_segment(117);

		settle();
		repeat (8) @(negedge clk);
		tracker.flush_leftovers();

		$display("covered %0d transactions under %0d register settings, %0d pool refills",
			items_sent, settings_loaded, tracker.refills);
		$display("results: %0d ok, %0d pool empty, %0d nothing in use, %0d size mismatch",
			tracker.status_tally[fcpa_pkg::ST_OK], tracker.status_tally[fcpa_pkg::ST_EMPTY],
			tracker.status_tally[fcpa_pkg::ST_NONE_USED],
			tracker.status_tally[fcpa_pkg::ST_SIZE]);
		if (tracker.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fcpa_pkg.sv
rtl/fcpa_ram.sv
rtl/fixed_chunk_pool_allocator_core.sv
tb/sv/fixed_chunk_pool_allocator_core_tb.sv
